// ===== hdl/ucal_pkg.sv =====
// shared constants and month table for the utc calendar pipeline
package ucal_pkg;

  // seconds of a day split as 128 * 675, quotient by reciprocal multiply
  localparam logic [25:0] DayRecip     = 26'd50903317;  // ceil(2^35 / 675)
  localparam int unsigned DayShift     = 35;
  localparam logic [16:0] SecsPerDay   = 17'd86400;

  // time of day
  localparam logic [17:0] HourRecip    = 18'd149131;    // ceil(2^29 / 3600)
  localparam int unsigned HourShift    = 29;
  localparam logic [11:0] SecsPerHour  = 12'd3600;
  localparam logic [12:0] MinRecip     = 13'd4370;      // ceil(2^18 / 60)
  localparam int unsigned MinShift     = 18;
  localparam logic [5:0]  SecsPerMin   = 6'd60;

  // date: day count rebased to 1968-01-01, four-year blocks of 1461 days
  localparam logic [15:0] RebaseDays   = 16'd731;       // 1968 and 1969
  localparam logic [15:0] SkipLeapDay  = 16'd47541;     // first day at 2100-03-01
  localparam logic [5:0]  SkipLeapBlock = 6'd33;        // block holding 2100
  localparam logic [16:0] BlockRecip   = 17'd91868;     // ceil(2^27 / 1461)
  localparam int unsigned BlockShift   = 27;
  localparam logic [15:0] BlockDays    = 16'd1461;
  localparam logic [15:0] WeekOffset   = 16'd4;         // 1970-01-01 is a thursday
  localparam logic [16:0] WeekRecip    = 17'd74899;     // ceil(2^19 / 7)
  localparam int unsigned WeekShift    = 19;
  localparam logic [7:0]  BaseYear     = 8'd68;         // 1968 - 1900

  localparam int unsigned NumMonths    = 12;

  // first day of year index of each month
  function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
    logic [8:0] base;
    begin
      unique case (month)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && (month >= 4'd2)) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

endpackage

// ===== hdl/ucal_day_split.sv =====
// splits the second count into whole days and second of day
module ucal_day_split import ucal_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] secs_i,
  output logic [15:0] days_o,
  output logic [16:0] sec_of_day_o
);

  logic [50:0] prod_d, prod_q;
  logic [31:0] t_a_q, t_b_q;
  logic [15:0] days_b_q, days_c_q;
  logic [32:0] day_secs;
  logic [16:0] sec_of_day_d, sec_of_day_q;

  // divide by 128 with a shift, then by 675 with a reciprocal
  assign prod_d = 51'(secs_i[31:7]) * 51'(DayRecip);

  assign day_secs     = 33'(days_b_q) * 33'(SecsPerDay);
  assign sec_of_day_d = 17'(33'(t_b_q) - day_secs);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q       <= prod_d;
      t_a_q        <= secs_i;
      days_b_q     <= prod_q[50:DayShift];
      t_b_q        <= t_a_q;
      days_c_q     <= days_b_q;
      sec_of_day_q <= sec_of_day_d;
    end
  end

  assign days_o       = days_c_q;
  assign sec_of_day_o = sec_of_day_q;

endmodule

// ===== hdl/ucal_clock.sv =====
// hour, minute and second from the second of day
module ucal_clock import ucal_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] sec_of_day_i,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  logic [34:0] hprod_q;
  logic [16:0] sd_a_q;
  logic [4:0]  hour_b;
  logic [4:0]  hour_b_q, hour_c_q, hour_d_q;
  logic [11:0] min_secs_b, min_secs_b_q, min_secs_c_q;
  logic [24:0] mprod_c_q;
  logic [5:0]  minute_c;
  logic [5:0]  minute_d_q, second_d_q;
  logic [11:0] second_c;

  assign hour_b     = hprod_q[HourShift+4:HourShift];
  assign min_secs_b = 12'(sd_a_q - 17'(hour_b) * 17'(SecsPerHour));

  assign minute_c = mprod_c_q[MinShift+5:MinShift];
  assign second_c = min_secs_c_q - 12'(minute_c) * 12'(SecsPerMin);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hprod_q      <= 35'(sec_of_day_i) * 35'(HourRecip);
      sd_a_q       <= sec_of_day_i;
      hour_b_q     <= hour_b;
      min_secs_b_q <= min_secs_b;
      mprod_c_q    <= 25'(min_secs_b_q) * 25'(MinRecip);
      min_secs_c_q <= min_secs_b_q;
      hour_c_q     <= hour_b_q;
      hour_d_q     <= hour_c_q;
      minute_d_q   <= minute_c;
      second_d_q   <= second_c[5:0];
    end
  end

  assign hour_o   = hour_d_q;
  assign minute_o = minute_d_q;
  assign second_o = second_d_q;

endmodule

// ===== hdl/ucal_date.sv =====
// year, month, day, day of year and weekday from the day count
module ucal_date import ucal_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] days_i,
  output logic [7:0]  year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  mday_o,
  output logic [8:0]  yday_o,
  output logic [2:0]  wday_o
);

  // stage a: rebase, reciprocal products
  logic        late_a;
  logic [15:0] dadj_a, wkx_a;
  logic [32:0] bprod_a_q, wprod_a_q;
  logic [15:0] dadj_a_q, wkx_a_q;
  logic        late_a_q;

  // stage b: block number and remainders
  logic [5:0]  blk_b;
  logic [13:0] wq_b;
  logic [15:0] rem_b, wrem_b;
  logic [5:0]  blk_b_q;
  logic [10:0] rem_b_q;
  logic [2:0]  wday_b_q;
  logic        late_b_q;

  // stage c: year within block
  logic [1:0]  y4_c;
  logic [10:0] yd_c;
  logic [5:0]  blk_c_q;
  logic [1:0]  y4_c_q;
  logic [8:0]  yd_c_q;
  logic [2:0]  wday_c_q;
  logic        late_c_q;

  // stage d: month walk by compare
  logic        leap_d;
  logic        phantom_d;
  logic [3:0]  month_d;
  logic [8:0]  mday_d;
  logic [7:0]  year_q;
  logic [3:0]  month_q;
  logic [4:0]  mday_q;
  logic [8:0]  yday_q;
  logic [2:0]  wday_q;

  // dates from 2100-03-01 on get a phantom feb 29 so blocks stay 1461 days
  assign late_a = (days_i >= SkipLeapDay);
  assign dadj_a = days_i + RebaseDays + 16'(late_a);
  assign wkx_a  = days_i + WeekOffset;

  assign blk_b  = bprod_a_q[BlockShift+5:BlockShift];
  assign rem_b  = dadj_a_q - 16'(blk_b) * BlockDays;
  assign wq_b   = wprod_a_q[WeekShift+13:WeekShift];
  assign wrem_b = wkx_a_q - 16'(wq_b) * 16'd7;

  // first year of each block is the leap year
  always_comb begin
    priority if (rem_b_q < 11'd366) begin
      y4_c = 2'd0;
      yd_c = rem_b_q;
    end else if (rem_b_q < 11'd731) begin
      y4_c = 2'd1;
      yd_c = rem_b_q - 11'd366;
    end else if (rem_b_q < 11'd1096) begin
      y4_c = 2'd2;
      yd_c = rem_b_q - 11'd731;
    end else begin
      y4_c = 2'd3;
      yd_c = rem_b_q - 11'd1096;
    end
  end

  assign leap_d = (y4_c_q == 2'd0);

  // only 2100 itself carries the phantom day inside its day of year
  assign phantom_d = late_c_q && (blk_c_q == SkipLeapBlock) && (y4_c_q == 2'd0);

  always_comb begin
    month_d = 4'd0;
    for (int m = 1; m < NumMonths; m++) begin
      if (yd_c_q >= month_start(4'(m), leap_d)) begin
        month_d = 4'(m);
      end
    end
  end

  assign mday_d = yd_c_q - month_start(month_d, leap_d) + 9'd1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bprod_a_q <= 33'(dadj_a) * 33'(BlockRecip);
      wprod_a_q <= 33'(wkx_a) * 33'(WeekRecip);
      dadj_a_q  <= dadj_a;
      wkx_a_q   <= wkx_a;
      late_a_q  <= late_a;

      blk_b_q   <= blk_b;
      rem_b_q   <= rem_b[10:0];
      wday_b_q  <= wrem_b[2:0];
      late_b_q  <= late_a_q;

      blk_c_q   <= blk_b_q;
      y4_c_q    <= y4_c;
      yd_c_q    <= yd_c[8:0];
      wday_c_q  <= wday_b_q;
      late_c_q  <= late_b_q;

      year_q    <= BaseYear + {blk_c_q, 2'b00} + 8'(y4_c_q);
      month_q   <= month_d;
      mday_q    <= mday_d[4:0];
      yday_q    <= yd_c_q - 9'(phantom_d);
      wday_q    <= wday_c_q;
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign mday_o  = mday_q;
  assign yday_o  = yday_q;
  assign wday_o  = wday_q;

endmodule

// ===== hdl/unix_seconds_to_utc_calendar.sv =====
// top level of the unix seconds to utc calendar converter
//
// Converts a Unix second count into broken-down UTC time: years since 1900,
// month 0-11, day of month, hour, minute, second, weekday (0 is Sunday) and
// day of year. A request with the sign bit set is treated as zero. The
// design is an 8-stage pipeline with no loops: it takes one request every
// clock when the output side keeps up and presents each result on
// out_valid_o once it has passed all eight register stages, the input
// register included. The whole pipeline moves on one shared enable, so
// while a finished result waits on out_ready_i every stage holds and
// in_ready_o is low; bubbles in flight are not squeezed out. Divisions by
// constants are shifts and reciprocal multiplies, and the year walk is
// replaced by four-year blocks counted from 1968 with a phantom leap day
// for 2100.
module unix_seconds_to_utc_calendar import ucal_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [32:0] epoch_seconds_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         year_since_1900_o,
  output logic [3:0]         month_index_o,
  output logic [4:0]         day_of_month_o,
  output logic [4:0]         hour_of_day_o,
  output logic [5:0]         minute_of_hour_o,
  output logic [5:0]         second_of_minute_o,
  output logic [2:0]         weekday_o,
  output logic [8:0]         day_of_year_o
);

  localparam int unsigned Depth = 8;

  logic             en;
  logic [Depth-1:0] valid_d, valid_q;
  logic [31:0]      secs_q;
  logic [15:0]      days;
  logic [16:0]      sec_of_day;

  // pipeline advances unless the last stage holds an untaken result
  assign en         = !valid_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;

  // valid bits ride alongside the data stages
  assign valid_d = {valid_q[Depth-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // input register, negative counts clamp to the epoch
  always_ff @(posedge clk_i) begin
    if (en) begin
      secs_q <= epoch_seconds_i[32] ? 32'd0 : epoch_seconds_i[31:0];
    end
  end

  // stages 2 to 4: days and second of day
  ucal_day_split u_day_split (
    .clk_i        (clk_i),
    .en_i         (en),
    .secs_i       (secs_q),
    .days_o       (days),
    .sec_of_day_o (sec_of_day)
  );

  // stages 5 to 8: time of day
  ucal_clock u_clock (
    .clk_i        (clk_i),
    .en_i         (en),
    .sec_of_day_i (sec_of_day),
    .hour_o       (hour_of_day_o),
    .minute_o     (minute_of_hour_o),
    .second_o     (second_of_minute_o)
  );

  // stages 5 to 8: calendar date, same depth as the time of day path
  ucal_date u_date (
    .clk_i   (clk_i),
    .en_i    (en),
    .days_i  (days),
    .year_o  (year_since_1900_o),
    .month_o (month_index_o),
    .mday_o  (day_of_month_o),
    .yday_o  (day_of_year_o),
    .wday_o  (weekday_o)
  );

  assign out_valid_o = valid_q[Depth-1];

`ifndef SYNTHESIS
  // date fields stay in calendar range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_index_o <= 4'd11) && (day_of_month_o != 5'd0) &&
                    (weekday_o <= 3'd6) && (day_of_year_o <= 9'd365))
    else $error("calendar field out of range");

  // time of day fields stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_of_day_o <= 5'd23) && (minute_of_hour_o <= 6'd59) &&
                    (second_of_minute_o <= 6'd59))
    else $error("time of day field out of range");

  // in january the day of year follows the day of month
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (month_index_o == 4'd0)) |->
      (day_of_year_o == 9'(day_of_month_o) - 9'd1))
    else $error("day of year disagrees with january date");
`endif

endmodule
